@@ rtl/rca_pkg.sv @@
// Shared types and constants for the radius-3 cellular automaton block.
// No dependencies; used by rca_cell, rca_popcnt and the top level.
package rca_pkg;

   localparam int RULE_WORDS   = 8;
   localparam int RULE_W       = 16;
   localparam int RULE_ENTRIES = RULE_WORDS * RULE_W;
   localparam int CSR_IDX_W    = $clog2(RULE_WORDS);
   localparam int NBHD_W       = 7;    // cells at offsets -3..+3
   localparam int RADIUS       = 3;

   localparam int IDX_FIELD_W  = 10;
   localparam int REQ_TDATA_W  = 16;
   localparam int REQ_TUSER_W  = 2;
   localparam int POP_W        = 11;
   localparam int RSP_W        = POP_W + 1;
   localparam int RSP_TDATA_W  = 16;
   localparam logic [POP_W-1:0] POP_MAX = '1;

   // cells summed per cycle by the population counter
   localparam int SEG_BITS     = 64;

   typedef enum logic [REQ_TUSER_W-1:0] {
      REQ_WRITE = 2'd0,
      REQ_STEP  = 2'd1,
      REQ_READ  = 2'd2
   } req_kind_type;

endpackage

@@ rtl/rca_cell.sv @@
// One cell of the ring: holds a single bit, loads it on a write or
// replaces it with the rule entry picked by its neighborhood on a step.
// Depends on rca_pkg.
module rca_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic                                 wr_en,
   input  logic                                 wr_val,
   input  logic [rca_pkg::NBHD_W-1:0]           nbhd,
   input  logic [rca_pkg::RULE_ENTRIES-1:0]     rule,
   output logic                                 state
);

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      if (wr_en) begin
         state_in = wr_val;
      end else if (step) begin
         state_in = rule[nbhd];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

@@ rtl/rca_popcnt.sv @@
// Live-cell counter: walks the ring one segment of SEG_BITS cells per cycle
// and accumulates the ones. Depends on rca_pkg.
module rca_popcnt #(
   parameter int CELLS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [CELLS-1:0]            cells,
   output logic                        done,
   output logic [$clog2(CELLS+1)-1:0]  total
);

   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int NSEG   = (CELLS + rca_pkg::SEG_BITS - 1) / rca_pkg::SEG_BITS;
   localparam int SEG_W  = (NSEG > 1) ? $clog2(NSEG) : 1;
   localparam int PAD    = NSEG * rca_pkg::SEG_BITS;
   localparam int ONES_W = $clog2(rca_pkg::SEG_BITS + 1);

   logic               busy_ff, busy_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [CNT_W-1:0]   acc_ff, acc_in;
   logic [PAD-1:0]     padded;
   logic [rca_pkg::SEG_BITS-1:0] seg_bits;
   logic [ONES_W-1:0]  seg_ones;
   logic [CNT_W-1:0]   sum;
   logic               last;

   assign padded   = PAD'(cells);
   assign seg_bits = padded[seg_ff * rca_pkg::SEG_BITS +: rca_pkg::SEG_BITS];
   assign seg_ones = ONES_W'($countones(seg_bits));
   assign sum      = acc_ff + CNT_W'(seg_ones);
   assign last     = (seg_ff == SEG_W'(NSEG - 1));

   always_comb begin
      busy_in = busy_ff;
      seg_in  = seg_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         seg_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            seg_in = seg_ff + SEG_W'(1);
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         seg_ff  <= '0;
         acc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         seg_ff  <= seg_in;
         acc_ff  <= acc_in;
      end
   end

   assign done  = busy_ff && last;
   assign total = sum;

endmodule

@@ rtl/radius3_cellular_automaton_top.sv @@
// Radius-3 one-dimensional cellular automaton on a ring of CELLS cells.
// Depends on rca_pkg, rca_cell and rca_popcnt.
//
// Usage:
//   req channel: tuser = request kind (write cell, step, read cell);
//     tdata = cell index, then the value to write.
//   rsp channel: one item per request: live-cell population (saturating at
//     2047) and the cell value on a read.
//   csr port: eight 16-bit rule words; they must be written only while the
//     block is idle: a rule for the user that the block does not enforce.
// Flow: reads and writes answer via the output register (the skid slot if
//   that is full); requests are taken every cycle while idle and the skid
//   is empty. A step updates all cells at the edge that takes it, then the
//   counter sums 64 cells per cycle; requests wait until the step answers.
// Reset clears all cells, the population and the rule words.
// A stalled rsp side: the output register holds its item and a skid slot
//   takes one more result; requests stop when both are full.
module radius3_cellular_automaton_top #(
   parameter int CELLS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] cell_index, [10] cell_value, rest zero
   input  logic [rca_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] req_type
   input  logic [rca_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [10:0] population, [11] read_value, rest zero
   output logic [rca_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [rca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rca_pkg::RULE_W-1:0]          csr_wdata
);

   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SEL_W = (IDX_W > rca_pkg::IDX_FIELD_W) ? IDX_W : rca_pkg::IDX_FIELD_W;
   localparam int CNT_W = $clog2(CELLS + 1);
   localparam int CW    = (CNT_W > rca_pkg::POP_W) ? CNT_W : rca_pkg::POP_W;

   typedef enum logic {ST_IDLE, ST_COUNT} state_type;

   // rule words
   logic [rca_pkg::RULE_W-1:0]       rule_ff [rca_pkg::RULE_WORDS];
   logic [rca_pkg::RULE_ENTRIES-1:0] rule_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < rca_pkg::RULE_WORDS; w++) begin
            rule_ff[w] <= '0;
         end
      end else if (csr_we) begin
         rule_ff[csr_index] <= csr_wdata;
      end
   end

   for (genvar w = 0; w < rca_pkg::RULE_WORDS; w++) begin : g_rule
      assign rule_vec[w*rca_pkg::RULE_W +: rca_pkg::RULE_W] = rule_ff[w];
   end

   // request decode
   state_type                   state_ff, state_in;
   logic                        skid_valid_ff, skid_valid_in;
   logic [rca_pkg::RSP_W-1:0]   skid_data_ff, skid_data_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rca_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]            pop_ff, pop_in;

   rca_pkg::req_kind_type              req_kind;
   logic [rca_pkg::IDX_FIELD_W-1:0]    req_index;
   logic                               req_value;
   logic                               req_fire;
   logic                               is_write, is_step, is_read;
   logic [SEL_W-1:0]                   sel_wide;
   logic [IDX_W-1:0]                   cell_sel;
   logic                               in_range;
   logic                               cur_bit;
   logic                               wr_fire;
   logic                               step_fire;
   logic [CELLS-1:0]                   cell_q;
   logic                               cnt_done;
   logic [CNT_W-1:0]                   cnt_total;

   assign req_kind  = rca_pkg::req_kind_type'(req_tuser);
   assign req_index = req_tdata[rca_pkg::IDX_FIELD_W-1:0];
   assign req_value = req_tdata[rca_pkg::IDX_FIELD_W];
   assign req_tready = (state_ff == ST_IDLE) && !skid_valid_ff;
   assign req_fire  = req_tvalid && req_tready;

   always_comb begin
      is_write = 1'b0;
      is_step  = 1'b0;
      is_read  = 1'b0;
      unique case (req_kind)
         rca_pkg::REQ_WRITE: is_write = 1'b1;
         rca_pkg::REQ_STEP:  is_step  = 1'b1;
         rca_pkg::REQ_READ:  is_read  = 1'b1;
         default: ;  // unused code: population only
      endcase
   end

   assign sel_wide  = SEL_W'(req_index);
   assign cell_sel  = sel_wide[IDX_W-1:0];
   assign in_range  = int'(req_index) < CELLS;
   assign cur_bit   = in_range ? cell_q[cell_sel] : 1'b0;
   assign wr_fire   = req_fire && is_write && in_range;
   assign step_fire = req_fire && is_step;

   // ring of cells, each wired to its six neighbors with wraparound
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic [rca_pkg::NBHD_W-1:0] nbhd;
      for (genvar k = 0; k < rca_pkg::NBHD_W; k++) begin : g_tap
         localparam int P = (i + CELLS - rca_pkg::RADIUS + k) % CELLS;
         assign nbhd[k] = cell_q[P];
      end
      rca_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .step   (step_fire),
         .wr_en  (wr_fire && (cell_sel == IDX_W'(i))),
         .wr_val (req_value),
         .nbhd   (nbhd),
         .rule   (rule_vec),
         .state  (cell_q[i])
      );
   end

   rca_popcnt #(.CELLS(CELLS)) u_popcnt (
      .clock (clock),
      .reset (reset),
      .start (step_fire),
      .cells (cell_q),
      .done  (cnt_done),
      .total (cnt_total)
   );

   // population and result
   logic [CW-1:0]               pop_wide;
   logic [rca_pkg::POP_W-1:0]   pop_sat;
   logic                        res_fire;
   logic [rca_pkg::RSP_W-1:0]   res_data;
   logic                        out_take;

   always_comb begin
      pop_in = pop_ff;
      if (cnt_done) begin
         pop_in = cnt_total;
      end else if (wr_fire && (cur_bit != req_value)) begin
         pop_in = req_value ? pop_ff + CNT_W'(1) : pop_ff - CNT_W'(1);
      end
   end

   assign pop_wide = CW'(pop_in);
   assign pop_sat  = (pop_wide > CW'(rca_pkg::POP_MAX)) ? rca_pkg::POP_MAX
                                                        : pop_wide[rca_pkg::POP_W-1:0];
   assign res_fire = (req_fire && !is_step) || cnt_done;
   assign res_data = {req_fire && is_read && cur_bit, pop_sat};
   assign out_take = rsp_valid_ff && rsp_tready;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;

      unique case (state_ff)
         ST_IDLE:  if (step_fire) state_in = ST_COUNT;
         ST_COUNT: if (cnt_done)  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase

      if (out_take) begin
         rsp_valid_in  = skid_valid_ff;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      // skid is always empty when a result is produced
      if (res_fire) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         pop_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         pop_ff        <= pop_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rca_pkg::RSP_TDATA_W'(rsp_data_ff);

   // checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot full while output register empty");

   a_step_enters_count: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> (state_ff == ST_COUNT))
      else $error("step did not start the population count");

   a_cells_hold_in_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT) && $past(state_ff == ST_COUNT) |-> $stable(cell_q))
      else $error("cells changed while counting");

   a_pop_bound: assert property (@(posedge clock) disable iff (reset)
      int'(pop_ff) <= CELLS)
      else $error("population above ring size");

   a_done_only_in_count: assert property (@(posedge clock) disable iff (reset)
      cnt_done |-> (state_ff == ST_COUNT))
      else $error("count finished outside a step");

endmodule

@@ bench/rca_ring_checker.sv @@
// Checker for the radius-3 cellular automaton: watches req, rsp and csr traffic,
// keeps its own copy of the ring and rule table, and compares every rsp item.
// Depends on rca_pkg for field widths and request kinds.
`timescale 1ns / 1ps

module rca_ring_checker #(
   parameter int CELLS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [rca_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [rca_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [rca_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [rca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rca_pkg::RULE_W-1:0]          csr_wdata,
   output int                                  pending_results,
   output int                                  mismatch_count
);

   typedef struct packed {
      logic [rca_pkg::POP_W-1:0] population;
      logic                      read_value;
   } ca_answer_type;

   ca_answer_type                      due_answers[$];
   logic [rca_pkg::RULE_ENTRIES-1:0]   rule_table;
   logic [CELLS-1:0]                   ring;

   // all cells update at once; the ring wraps on every generation
   function automatic void next_generation();
      logic [CELLS-1:0]           nxt;
      logic [rca_pkg::NBHD_W-1:0] nbhd;
      for (int i = 0; i < CELLS; i++) begin
         for (int k = 0; k < rca_pkg::NBHD_W; k++)
            nbhd[k] = ring[(i + CELLS - rca_pkg::RADIUS + k) % CELLS];
         nxt[i] = rule_table[nbhd];
      end
      ring = nxt;
   endfunction

   function automatic ca_answer_type apply_request(
         input logic [rca_pkg::REQ_TUSER_W-1:0] kind,
         input logic [rca_pkg::IDX_FIELD_W-1:0] idx,
         input logic val);
      ca_answer_type ans;
      int            live;
      ans.read_value = 1'b0;
      case (kind)
         rca_pkg::REQ_WRITE: begin
            if (idx < CELLS)
               ring[idx] = val;
         end
         rca_pkg::REQ_STEP: begin
            next_generation();
         end
         rca_pkg::REQ_READ: begin
            if (idx < CELLS)
               ans.read_value = ring[idx];
         end
         default: ;   // unused code: no change
      endcase
      live = $countones(ring);
      ans.population = (live > rca_pkg::POP_MAX) ? rca_pkg::POP_MAX
                                                 : live[rca_pkg::POP_W-1:0];
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      ca_answer_type got;
      ca_answer_type want;
      if (reset) begin
         ring            = '0;
         rule_table      = '0;
         due_answers.delete();
         pending_results = 0;
         mismatch_count  = 0;
      end else begin
         if (csr_we)
            rule_table[csr_index*rca_pkg::RULE_W +: rca_pkg::RULE_W] = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.population = rsp_tdata[rca_pkg::POP_W-1:0];
            got.read_value = rsp_tdata[rca_pkg::POP_W];
            if (due_answers.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected item, population %0d read_value %0d", $time,
                        got.population, got.read_value);
            end else begin
               want = due_answers.pop_front();
               if (got.population !== want.population) begin
                  mismatch_count++;
                  $display("%0t: population expected %0d got %0d", $time,
                           want.population, got.population);
               end
               if (got.read_value !== want.read_value) begin
                  mismatch_count++;
                  $display("%0t: read_value expected %0d got %0d", $time,
                           want.read_value, got.read_value);
               end
            end
         end
         if (req_tvalid && req_tready)
            due_answers.push_back(apply_request(req_tuser,
                                                req_tdata[rca_pkg::IDX_FIELD_W-1:0],
                                                req_tdata[rca_pkg::IDX_FIELD_W]));
         pending_results = due_answers.size();
      end
   end

endmodule

@@ bench/radius3_cellular_automaton_top_test.sv @@
// Stimulus and verdict for the radius-3 cellular automaton block: directed and
// random cell writes, reads and generation steps under several rule tables.
// Depends on rca_pkg, the block itself and rca_ring_checker.
`timescale 1ns / 1ps

module radius3_cellular_automaton_top_test;

   localparam int CELLS          = 1024;
   localparam int IDX_W          = rca_pkg::IDX_FIELD_W;
   localparam logic [rca_pkg::REQ_TUSER_W-1:0] REQ_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 80;
   localparam int PHASE_ITEMS    = 120;
   localparam logic [rca_pkg::RULE_ENTRIES-1:0] RULE_ZERO   = '0;
   localparam logic [rca_pkg::RULE_ENTRIES-1:0] RULE_ONES   = '1;
   localparam logic [rca_pkg::RULE_ENTRIES-1:0] RULE_KEEP   = {8{16'hFF00}};  // new = center
   localparam logic [rca_pkg::RULE_ENTRIES-1:0] RULE_SHIFT  = {8{16'hF0F0}};  // new = left
   localparam logic [rca_pkg::RULE_ENTRIES-1:0] RULE_STRIPE = {8{16'h5555}};  // !(offset -3)

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [rca_pkg::REQ_TDATA_W-1:0]  req_tdata;
   logic [rca_pkg::REQ_TUSER_W-1:0]  req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [rca_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   logic                             csr_we;
   logic [rca_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [rca_pkg::RULE_W-1:0]       csr_wdata;

   int                      pending_results;
   int                      mismatch_count;
   logic                    req_taken = 1'b0;
   logic                    rsp_taken = 1'b0;
   int                      idle_cycles = 0;
   bit                      send_quiet = 1'b0;
   bit                      hold_rsp = 1'b0;

   radius3_cellular_automaton_top #(.CELLS(CELLS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rca_ring_checker #(.CELLS(CELLS)) ring_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // handshakes seen at the rising edge, read by the drivers at the falling edge
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      rsp_taken <= rsp_tvalid && rsp_tready;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random stalls, quiet stretches, and one long hold-off on request
   initial begin : receiver
      int stall;
      int taken_items;
      bit hold_done;
      rsp_tready  = 1'b0;
      taken_items = 0;
      hold_done   = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            stall     = HOLD_CYCLES;
            hold_done = 1'b1;
         end else if ((taken_items / 48) % 3 == 2) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_taken);
         taken_items++;
      end
   end

   task automatic offer_item(input logic [rca_pkg::REQ_TUSER_W-1:0] kind,
                             input logic [IDX_W-1:0] idx,
                             input logic val);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {{(rca_pkg::REQ_TDATA_W-IDX_W-1){1'b0}}, val, idx};
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_taken);
   endtask

   // wait for every answer, then let the block settle before touching the rules
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_rules(input logic [rca_pkg::RULE_ENTRIES-1:0] table_bits);
      for (int w = 0; w < rca_pkg::RULE_WORDS; w++) begin
         csr_we    <= 1'b1;
         csr_index <= w[rca_pkg::CSR_IDX_W-1:0];
         csr_wdata <= table_bits[w*rca_pkg::RULE_W +: rca_pkg::RULE_W];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_item();
      int               pick;
      logic [IDX_W-1:0] idx;
      logic             val;
      pick = $urandom_range(0, 99);
      val  = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0)
         idx = $urandom_range(0, 1) ? IDX_W'(CELLS - 1 - $urandom_range(0, 3))
                                    : IDX_W'($urandom_range(0, 3));
      else
         idx = IDX_W'($urandom_range(0, CELLS - 1));
      if (pick < 50)
         offer_item(rca_pkg::REQ_WRITE, idx, val);
      else if (pick < 78)
         offer_item(rca_pkg::REQ_READ, idx, val);
      else if (pick < 94)
         offer_item(rca_pkg::REQ_STEP, idx, val);
      else
         offer_item(REQ_UNUSED, idx, val);
   endtask

   initial begin : stimulus
      logic [rca_pkg::RULE_ENTRIES-1:0] phase_rules [7];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = rca_pkg::REQ_WRITE;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, rules still cleared by reset
      offer_item(rca_pkg::REQ_WRITE, 10'd0, 1'b1);
      offer_item(rca_pkg::REQ_WRITE, 10'd1023, 1'b1);
      offer_item(rca_pkg::REQ_WRITE, 10'd512, 1'b1);
      offer_item(rca_pkg::REQ_WRITE, 10'd512, 1'b1);   // same value again: count unchanged
      offer_item(rca_pkg::REQ_WRITE, 10'd7, 1'b0);     // clearing a dead cell
      offer_item(rca_pkg::REQ_READ, 10'd0, 1'b0);
      offer_item(rca_pkg::REQ_READ, 10'd1023, 1'b1);
      offer_item(rca_pkg::REQ_READ, 10'd7, 1'b1);
      offer_item(REQ_UNUSED, 10'd1023, 1'b1);
      offer_item(rca_pkg::REQ_STEP, 10'd0, 1'b0);      // all-zero rule kills everything
      offer_item(rca_pkg::REQ_READ, 10'd0, 1'b0);
      drain();

      // wraparound across the ring ends with a shift rule
      load_rules(RULE_SHIFT);
      offer_item(rca_pkg::REQ_WRITE, 10'd1023, 1'b1);
      offer_item(rca_pkg::REQ_WRITE, 10'd3, 1'b1);
      offer_item(rca_pkg::REQ_STEP, 10'd0, 1'b0);
      offer_item(rca_pkg::REQ_READ, 10'd0, 1'b0);
      offer_item(rca_pkg::REQ_READ, 10'd4, 1'b0);
      offer_item(rca_pkg::REQ_READ, 10'd1023, 1'b0);
      offer_item(rca_pkg::REQ_STEP, 10'd1023, 1'b1);
      offer_item(rca_pkg::REQ_READ, 10'd1, 1'b0);
      drain();

      phase_rules[0] = RULE_ONES;
      phase_rules[1] = RULE_KEEP;
      phase_rules[2] = {$urandom, $urandom, $urandom, $urandom};
      phase_rules[3] = {$urandom, $urandom, $urandom, $urandom};
      phase_rules[4] = RULE_STRIPE;
      phase_rules[5] = {$urandom, $urandom, $urandom, $urandom};
      phase_rules[6] = RULE_ZERO;

      for (int p = 0; p < 7; p++) begin
         load_rules(phase_rules[p]);
         send_quiet = (p == 3) || ($urandom_range(0, 2) == 0);
         // back-to-back items against a stalled rsp side fill the block
         if (p == 3)
            hold_rsp = 1'b1;
         repeat (PHASE_ITEMS) random_item();
         drain();
      end
      send_quiet = 1'b0;

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
